// ===== design/cgd_pkg.sv =====
// Shared constants and helpers for the chain gap distance score unit.
package cgd_pkg;

  // Default coordinate and sequence widths
  localparam int COORD_BITS_DEF = 20;
  localparam int SEQ_BITS_DEF   = 16;

  // Fixed result field widths
  localparam int TERM_W  = 21;
  localparam int TOTAL_W = 32;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== design/cgd_cmpsub.sv =====
// Shared compare-and-subtract unit used by the root and division steps.
module cgd_cmpsub #(
  parameter int W = 25
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] wide;

  // Subtract with borrow out; no borrow means a >= b
  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];

endmodule

// ===== design/cgd_core.sv =====
// Term sequencer: sum of squares, bit-pair square root, restoring division.
module cgd_core
  import cgd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] mag_x,
  input  logic [COORD_BITS-1:0] mag_y,
  input  logic [COORD_BITS-1:0] mag_z,
  input  logic [SEQ_BITS-1:0]   missing,
  output logic                  done,
  output logic [TERM_W-1:0]     term
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int REM_W  = max_int(ROOT_W + 1, SEQ_BITS);
  localparam int ALU_W  = REM_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int QX_W   = max_int(ROOT_W, TERM_W);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_SQ   = 5'b00010,
    C_ROOT = 5'b00100,
    C_DIV  = 5'b01000,
    C_DONE = 5'b10000
  } core_state_t;

  core_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   prod_r, prod_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic [COORD_BITS-1:0] sq_op;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_diff;
  logic                  alu_ge;
  logic [QX_W-1:0]       quot_x;

  // Pick the axis to square this cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_x;
      2'd1:    sq_op = mag_y;
      2'd2:    sq_op = mag_z;
      default: sq_op = '0;
    endcase
  end

  // Route operands into the shared unit
  always_comb begin
    if (state_r == C_ROOT) begin
      alu_a = {rem_r, sum_r[SUM_W-1 -: 2]};
      alu_b = ALU_W'({root_r, 2'b01});
    end else begin
      alu_a = ALU_W'({rem_r, root_r[ROOT_W-1]});
      alu_b = ALU_W'(missing);
    end
  end

  cgd_cmpsub #(.W(ALU_W)) u_cmpsub (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  // Sequence the phases
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          state_nxt = C_SQ;
          cnt_nxt   = '0;
          prod_nxt  = '0;
          sum_nxt   = '0;
        end
      end
      C_SQ: begin
        prod_nxt = sq_op * sq_op;
        sum_nxt  = sum_r + SUM_W'(prod_r);
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = C_ROOT;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          rem_nxt   = '0;
          root_nxt  = '0;
        end
      end
      C_ROOT: begin
        sum_nxt  = sum_r << 2;
        rem_nxt  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = C_DIV;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          rem_nxt   = '0;
        end
      end
      C_DIV: begin
        rem_nxt  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  // Saturate the quotient into the term field
  assign quot_x = QX_W'(root_r);
  assign term   = (quot_x > QX_W'((1 << TERM_W) - 1)) ? {TERM_W{1'b1}} : quot_x[TERM_W-1:0];
  assign done   = (state_r == C_DONE);

endmodule

// ===== design/chain_gap_distance_score_unit.sv =====
// Top level of the chain gap distance score unit: anchor state, handshakes, total.
//
// Residues arrive on the in_ channel (valid/ready), one result leaves per residue
// on the out_ channel (valid/ready). Coordinates carry 8 fraction bits.
// A residue that does not close a gap with a sequence step above one goes from
// its transfer through the hold state to the result register. A residue that
// closes such a gap runs through the term sequencer: squaring of the three
// axes on one shared multiplier, COORD_BITS+1 square root steps and
// COORD_BITS+1 division steps on one shared compare-subtract unit, then on
// to the hold state. in_ready is high only when no residue is in progress, so
// one residue is handled at a time.
// The result register holds a finished result while the receiver stalls; the
// next residue is taken meanwhile, and its result waits until the register frees.
// Synchronous active-low reset clears the anchor, the pending gap, the running
// total and both valid flags.
module chain_gap_distance_score_unit
  import cgd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_model_start,
  input  logic                         in_chain_start,
  input  logic                         in_coords_defined,
  input  logic [SEQ_BITS-1:0]          in_seq_number,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_gap_closed,
  output logic [TERM_W-1:0]            out_gap_term,
  output logic                         out_order_error,
  output logic [TOTAL_W-1:0]           out_model_total
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic                  anchor_valid_r;
  logic [SEQ_BITS-1:0]   anchor_seq_r;
  logic [COORD_BITS-1:0] anchor_x_r, anchor_y_r, anchor_z_r;
  logic                  gap_pending_r;
  logic [TOTAL_W-1:0]    total_r;

  logic [COORD_BITS-1:0] mag_x_r, mag_y_r, mag_z_r;
  logic [SEQ_BITS-1:0]   missing_r;
  logic                  pend_closed_r, pend_err_r;
  logic [TERM_W-1:0]     pend_term_r;

  logic                  out_valid_r;
  logic                  out_closed_r, out_err_r;
  logic [TERM_W-1:0]     out_term_r;
  logic [TOTAL_W-1:0]    out_total_r;

  logic                  in_xfer, out_free;
  logic                  anchor_eff, gap_eff, closing, seq_err, go;
  logic signed [SEQ_BITS:0] seq_diff;
  logic                  core_done;
  logic [TERM_W-1:0]     core_term;
  logic [TOTAL_W:0]      total_sum;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic signed [COORD_BITS:0] n;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    n = -d;
    return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  assign in_ready = (state_r == T_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Classify the arriving residue against the anchor
  assign anchor_eff = anchor_valid_r && !in_chain_start;
  assign gap_eff    = gap_pending_r && !in_chain_start;
  assign closing    = in_coords_defined && anchor_eff && gap_eff;
  assign seq_diff   = $signed({1'b0, in_seq_number}) - $signed({1'b0, anchor_seq_r});
  assign seq_err    = (seq_diff <= $signed((SEQ_BITS + 1)'(1)));
  assign go         = closing && !seq_err;

  cgd_core #(
    .COORD_BITS (COORD_BITS),
    .SEQ_BITS   (SEQ_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer && go),
    .mag_x   (mag_x_r),
    .mag_y   (mag_y_r),
    .mag_z   (mag_z_r),
    .missing (missing_r),
    .done    (core_done),
    .term    (core_term)
  );

  // Saturating add of the finished term
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(core_term);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (in_xfer) begin
          state_nxt = go ? T_BUSY : T_HOLD;
        end
      end
      T_BUSY: begin
        if (core_done) begin
          state_nxt = T_HOLD;
        end
      end
      T_HOLD: begin
        if (out_free) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Control state and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      anchor_valid_r <= 1'b0;
      anchor_seq_r   <= '0;
      anchor_x_r     <= '0;
      anchor_y_r     <= '0;
      anchor_z_r     <= '0;
      gap_pending_r  <= 1'b0;
      total_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        if (in_model_start) begin
          total_r <= '0;
        end
        if (in_coords_defined) begin
          anchor_valid_r <= 1'b1;
          anchor_seq_r   <= in_seq_number;
          anchor_x_r     <= in_pos_x;
          anchor_y_r     <= in_pos_y;
          anchor_z_r     <= in_pos_z;
          gap_pending_r  <= 1'b0;
        end else begin
          anchor_valid_r <= anchor_eff;
          gap_pending_r  <= gap_eff || (anchor_eff && (anchor_seq_r < in_seq_number));
        end
      end
      if (state_r == T_BUSY && core_done) begin
        total_r <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
      end
      // Hand the finished result to the output register, drop it once taken
      if (state_r == T_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operands and pending result fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_x_r       <= abs_diff(in_pos_x, anchor_x_r);
      mag_y_r       <= abs_diff(in_pos_y, anchor_y_r);
      mag_z_r       <= abs_diff(in_pos_z, anchor_z_r);
      missing_r     <= seq_diff[SEQ_BITS-1:0] - SEQ_BITS'(1);
      pend_closed_r <= closing;
      pend_err_r    <= closing && seq_err;
      pend_term_r   <= '0;
    end
    if (state_r == T_BUSY && core_done) begin
      pend_term_r <= core_term;
    end
    if (state_r == T_HOLD && out_free) begin
      out_closed_r <= pend_closed_r;
      out_err_r    <= pend_err_r;
      out_term_r   <= pend_term_r;
      out_total_r  <= total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gap_closed  = out_closed_r;
  assign out_gap_term    = out_term_r;
  assign out_order_error = out_err_r;
  assign out_model_total = out_total_r;

  // The sequencer only finishes while a residue is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (state_r == T_BUSY))
    else $error("term sequencer finished with no residue in progress");

  // A closing residue with a real gap starts the sequencer
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && go) |=> (state_r == T_BUSY))
    else $error("gap closure did not start the term sequencer");

  // A nonzero term only comes with a clean gap closure
  a_term_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_term_r == '0) || (out_closed_r && !out_err_r)))
    else $error("nonzero term without a clean gap closure");

endmodule

// ===== tb/tb_chain_gap_distance_score_unit.sv =====
// Self-checking testbench for the chain gap distance score unit.
`timescale 1ns / 1ps

module tb_chain_gap_distance_score_unit;
  import cgd_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 8;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [COORD_BITS_DEF-1:0] POS_MAX = {1'b0, {(COORD_BITS_DEF-1){1'b1}}};
  localparam logic signed [COORD_BITS_DEF-1:0] POS_MIN = {1'b1, {(COORD_BITS_DEF-1){1'b0}}};
  localparam longint unsigned TERM_LIMIT = (64'd1 << TERM_W) - 1;
  localparam longint unsigned TOTAL_LIMIT = (64'd1 << TOTAL_W) - 1;

  typedef struct packed {
    logic                              model_start;
    logic                              chain_start;
    logic                              coords_defined;
    logic [SEQ_BITS_DEF-1:0]           seq;
    logic signed [COORD_BITS_DEF-1:0]  x;
    logic signed [COORD_BITS_DEF-1:0]  y;
    logic signed [COORD_BITS_DEF-1:0]  z;
  } residue_t;

  typedef struct packed {
    logic               gap_closed;
    logic [TERM_W-1:0]  gap_term;
    logic               order_error;
    logic [TOTAL_W-1:0] model_total;
  } result_t;

  // Expected gap scores, worked out from the residues in transfer order
  class gap_score_board;
    bit                             anc_valid;
    bit [SEQ_BITS_DEF-1:0]          anc_seq;
    bit signed [COORD_BITS_DEF-1:0] anc_x;
    bit signed [COORD_BITS_DEF-1:0] anc_y;
    bit signed [COORD_BITS_DEF-1:0] anc_z;
    bit                             gap_open;
    bit [TOTAL_W-1:0]               total;
    result_t                        expected_q[$];
    int                             fails;
    int                             n_checked;
    int                             n_closed;
    int                             n_order;
    int                             n_at_ceiling;

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function result_t gap_score_step(residue_t r);
      result_t         res;
      int              step;
      longint          dx;
      longint          dy;
      longint          dz;
      longint unsigned sum;
      longint unsigned term;
      res = '0;
      // Start marks clear before the residue itself is handled
      if (r.model_start) total = '0;
      if (r.chain_start) begin
        anc_valid = 1'b0;
        gap_open = 1'b0;
      end
      if (r.coords_defined) begin
        if (gap_open && anc_valid) begin
          step = int'(r.seq) - int'(anc_seq);
          res.gap_closed = 1'b1;
          n_closed++;
          if (step <= 1) begin
            res.order_error = 1'b1;
            n_order++;
          end else begin
            dx = longint'($signed(r.x)) - longint'(anc_x);
            dy = longint'($signed(r.y)) - longint'(anc_y);
            dz = longint'($signed(r.z)) - longint'(anc_z);
            sum = dx * dx + dy * dy + dz * dz;
            term = floor_root(sum) / longint'(step - 1);
            if (term > TERM_LIMIT) term = TERM_LIMIT;
            sum = total + term;
            if (sum > TOTAL_LIMIT) total = '1;
            else total = sum[TOTAL_W-1:0];
            res.gap_term = term[TERM_W-1:0];
          end
        end
        // Every defined residue becomes the new anchor
        anc_valid = 1'b1;
        anc_seq = r.seq;
        anc_x = r.x;
        anc_y = r.y;
        anc_z = r.z;
        gap_open = 1'b0;
      end else if (anc_valid && anc_seq < r.seq) begin
        gap_open = 1'b1;
      end
      if (total == '1) n_at_ceiling++;
      res.model_total = total;
      return res;
    endfunction

    function void note_residue(residue_t r);
      expected_q.push_back(gap_score_step(r));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: result arrived with none expected: closed=%0b term=%0d err=%0b total=%0d",
                   $realtime, got.gap_closed, got.gap_term, got.order_error, got.model_total);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.gap_closed !== want.gap_closed || got.gap_term !== want.gap_term ||
          got.order_error !== want.order_error || got.model_total !== want.model_total) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: result %0d expected closed=%0b term=%0d err=%0b total=%0d, got closed=%0b term=%0d err=%0b total=%0d",
                   $realtime, n_checked, want.gap_closed, want.gap_term, want.order_error,
                   want.model_total, got.gap_closed, got.gap_term, got.order_error,
                   got.model_total);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_model_start;
  logic                              in_chain_start;
  logic                              in_coords_defined;
  logic [SEQ_BITS_DEF-1:0]           in_seq_number;
  logic signed [COORD_BITS_DEF-1:0]  in_pos_x;
  logic signed [COORD_BITS_DEF-1:0]  in_pos_y;
  logic signed [COORD_BITS_DEF-1:0]  in_pos_z;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_gap_closed;
  logic [TERM_W-1:0]                 out_gap_term;
  logic                              out_order_error;
  logic [TOTAL_W-1:0]                out_model_total;

  gap_score_board sb;
  bit rx_hold_req;
  int rx_left;
  bit rx_level;
  int rx_pick;
  int tx_calm;
  int items_sent;
  bit [SEQ_BITS_DEF-1:0] seq_at;

  chain_gap_distance_score_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_model_start    (in_model_start),
    .in_chain_start    (in_chain_start),
    .in_coords_defined (in_coords_defined),
    .in_seq_number     (in_seq_number),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_gap_closed    (out_gap_closed),
    .out_gap_term      (out_gap_term),
    .out_order_error   (out_order_error),
    .out_model_total   (out_model_total)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Note each input transfer and check each output transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_residue(residue_t'{in_model_start, in_chain_start, in_coords_defined,
                                 in_seq_number, in_pos_x, in_pos_y, in_pos_z});
    if (rst_n && out_valid && out_ready)
      sb.check_result(result_t'{out_gap_closed, out_gap_term, out_order_error,
                                out_model_total});
  end

  function automatic int gap_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_BITS_DEF-1:0] pick_coord();
    int p;
    p = $urandom_range(0, 7);
    if (p == 0) return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
    if (p < 4) return COORD_BITS_DEF'($urandom);
    return COORD_BITS_DEF'($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic residue_t make_residue(bit ms, bit cs, bit def,
                                            logic [SEQ_BITS_DEF-1:0] seq,
                                            logic [COORD_BITS_DEF-1:0] x,
                                            logic [COORD_BITS_DEF-1:0] y,
                                            logic [COORD_BITS_DEF-1:0] z);
    residue_t r;
    r.model_start = ms;
    r.chain_start = cs;
    r.coords_defined = def;
    r.seq = seq;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  // Receiver: random stalls, steady stretches, one long hold on request
  initial begin
    out_ready <= 1'b0;
    rx_left = 0;
    rx_level = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        rx_hold_req = 1'b0;
        rx_left = 0;
      end else begin
        if (rx_left == 0) begin
          rx_pick = $urandom_range(0, 99);
          if (rx_pick < 10) begin
            rx_level = 1'b1;
            rx_left = $urandom_range(40, 150);
          end else if (rx_pick < 60) begin
            rx_level = 1'b1;
            rx_left = $urandom_range(1, 8);
          end else begin
            rx_level = 1'b0;
            rx_left = gap_cycles();
          end
        end
        out_ready <= rx_level;
        rx_left--;
      end
    end
  end

  // Run stops here if the block hangs
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[chain_gap_distance_score_unit] ERROR");
    $finish;
  end

  // Hold valid and payload until the transfer; leave valid high afterwards
  task automatic offer_residue(residue_t r);
    in_valid <= 1'b1;
    in_model_start <= r.model_start;
    in_chain_start <= r.chain_start;
    in_coords_defined <= r.coords_defined;
    in_seq_number <= r.seq;
    in_pos_x <= r.x;
    in_pos_y <= r.y;
    in_pos_z <= r.z;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic pause_input(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic space_input();
    int p;
    if (tx_calm > 0) begin
      tx_calm--;
      return;
    end
    p = $urandom_range(0, 99);
    if (p < 6) tx_calm = $urandom_range(20, 60);
    else if (p >= 50) pause_input(gap_cycles());
  endtask

  task automatic feed(residue_t r);
    offer_residue(r);
    space_input();
  endtask

  // If results are pending, drop valid so the last residue is not offered again, then wait for every result
  task automatic drain_results();
    if (sb.pending() != 0) begin
      in_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end
  endtask

  // One anchor, a run of missing residues, then a closing or broken residue
  task automatic random_episode();
    bit ms;
    bit cs;
    int kind;
    int nmiss;
    bit [SEQ_BITS_DEF-1:0] anchor_at;
    ms = ($urandom_range(0, 11) == 0);
    cs = ($urandom_range(0, 7) == 0);
    kind = $urandom_range(0, 19);
    if (cs) seq_at = SEQ_BITS_DEF'($urandom);
    anchor_at = seq_at;
    feed(make_residue(ms, cs, 1'b1, seq_at, pick_coord(), pick_coord(), pick_coord()));
    nmiss = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    for (int k = 0; k < nmiss; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        // out-of-order missing residue: leaves the gap as it is
        feed(make_residue(1'b0, 1'b0, 1'b0, SEQ_BITS_DEF'(anchor_at - $urandom_range(0, 3)),
                          COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom),
                          COORD_BITS_DEF'($urandom)));
      end else begin
        seq_at = SEQ_BITS_DEF'(seq_at + $urandom_range(1, 4));
        feed(make_residue(1'b0, 1'b0, 1'b0, seq_at, COORD_BITS_DEF'($urandom),
                          COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom)));
      end
    end
    if (kind < 14) begin
      if ($urandom_range(0, 7) == 0) seq_at = SEQ_BITS_DEF'(seq_at + $urandom_range(1, 2000));
      else seq_at = SEQ_BITS_DEF'(seq_at + $urandom_range(1, 6));
      feed(make_residue(1'b0, 1'b0, 1'b1, seq_at, pick_coord(), pick_coord(), pick_coord()));
    end else if (kind < 16) begin
      seq_at = SEQ_BITS_DEF'(anchor_at + 1 - $urandom_range(0, 3));
      feed(make_residue(1'b0, 1'b0, 1'b1, seq_at, pick_coord(), pick_coord(), pick_coord()));
    end else if (kind == 16) begin
      seq_at = SEQ_BITS_DEF'(seq_at + $urandom_range(1, 6));
      feed(make_residue(1'($urandom_range(0, 1)), 1'b1, 1'b1, seq_at,
                        pick_coord(), pick_coord(), pick_coord()));
    end else begin
      feed(make_residue($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), SEQ_BITS_DEF'($urandom),
                        COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom),
                        COORD_BITS_DEF'($urandom)));
    end
  endtask

  initial begin
    int base;
    bit pressed;
    sb = new();
    rx_hold_req = 1'b0;
    tx_calm = 0;
    items_sent = 0;
    seq_at = '0;
    pressed = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_model_start <= 1'b0;
    in_chain_start <= 1'b0;
    in_coords_defined <= 1'b0;
    in_seq_number <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no anchor, extremes, order errors, marks, long and zero gaps
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd5, 0, 0, 0));
    feed(make_residue(1'b1, 1'b1, 1'b1, 16'd10, POS_MIN, POS_MIN, POS_MIN));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd11, POS_MAX, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd10, 0, POS_MAX, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd12, POS_MAX, POS_MAX, POS_MAX));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd13, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd13, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd20, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd3, 100, -100, 300));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd4, 0, 0, 0));
    feed(make_residue(1'b0, 1'b1, 1'b1, 16'd9, 5000, 6000, -7000));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd10, 0, 0, 0));
    feed(make_residue(1'b1, 1'b1, 1'b1, 16'd50, 2560, -2560, 1));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd51, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd60, 2560, -2560, 1));
    feed(make_residue(1'b1, 1'b0, 1'b0, 16'd61, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd70, -90000, 123456, 77));
    feed(make_residue(1'b0, 1'b1, 1'b1, 16'd0, 1, -1, 256));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'hFFFF, POS_MIN, POS_MAX, POS_MIN));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'hFFFF, POS_MAX, POS_MIN, POS_MAX));
    feed(make_residue(1'b0, 1'b0, 1'b0, 16'd0, 0, 0, 0));
    feed(make_residue(1'b0, 1'b0, 1'b1, 16'd1000, 0, 0, 0));
    drain_results();

    // Random episodes, with one long receiver hold partway through
    base = items_sent;
    seq_at = SEQ_BITS_DEF'($urandom);
    while (items_sent - base < RANDOM_ITEMS) begin
      if (!pressed && items_sent - base >= RANDOM_ITEMS / 2) begin
        pressed = 1'b1;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
          offer_residue(make_residue(1'b0, 1'b0, 1'($urandom_range(0, 1)),
                                     SEQ_BITS_DEF'(seq_at + k),
                                     pick_coord(), pick_coord(), pick_coord()));
        seq_at = SEQ_BITS_DEF'(seq_at + 12);
        drain_results();
        pause_input($urandom_range(5, 20));
      end
      random_episode();
    end

    pause_input(1);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d residues, %0d results checked: %0d gaps closed, %0d of them out of order.",
             items_sent, sb.n_checked, sb.n_closed, sb.n_order);
    $display("Total held at its ceiling on %0d results; %0d failures.",
             sb.n_at_ceiling, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("[chain_gap_distance_score_unit] OK");
    else
      $display("[chain_gap_distance_score_unit] ERROR");
    $finish;
  end

endmodule

// ===== chain_gap_distance_score_unit.f =====
design/cgd_pkg.sv
design/cgd_cmpsub.sv
design/cgd_core.sv
design/chain_gap_distance_score_unit.sv
tb/tb_chain_gap_distance_score_unit.sv
